[rtl/core/telrx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telrx_pkg: shared types and codes for the telnet receive command parser
// Telnet command codes, parse states and the event beat passed from the
// parser to the output buffer.
// ----------------------------------------------------------------------------
package telrx_pkg;

    // Telnet command codes
    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_DONT = 8'd254;
    localparam logic [7:0] CODE_IAC  = 8'd255;

    // Error codes carried on an error event
    localparam logic ERR_SE_NO_SB  = 1'b0;
    localparam logic ERR_SB_NESTED = 1'b1;

    typedef enum logic [1:0] {
        ST_DATA   = 2'd0,
        ST_CMD    = 2'd1,
        ST_OPT    = 2'd2,
        ST_SUBOPT = 2'd3
    } t_parse_state;

    typedef enum logic [2:0] {
        EV_DATA   = 3'd0,
        EV_SUBDAT = 3'd1,
        EV_SUBEND = 3'd2,
        EV_CMD    = 3'd3,
        EV_NEG    = 3'd4,
        EV_ERR    = 3'd5
    } t_event_kind;

    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  byte_value;
        logic [7:0]  option_code;
        logic        error_code;
    } t_event;

endpackage

[rtl/core/telrx_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telrx_parser: IAC layer state machine
// Holds the parse state, the pending verb and the open subnegotiation, and
// decodes each accepted byte into at most one event beat.
// ----------------------------------------------------------------------------
module telrx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_ev_valid,
    output telrx_pkg::t_event o_ev
);
    import telrx_pkg::*;

    t_parse_state r_state, n_state;
    logic         r_sub_active, n_sub_active;
    logic [7:0]   r_sub_option, n_sub_option;
    logic [7:0]   r_neg_verb, n_neg_verb;
    logic         ev_has;
    t_event       ev;
    t_event       ev_plain;

    // Plain byte: data, or subnegotiation data while one is open
    always_comb begin
        ev_plain             = '0;
        ev_plain.byte_value  = i_rx_byte;
        if (r_sub_active) begin
            ev_plain.kind        = EV_SUBDAT;
            ev_plain.option_code = r_sub_option;
        end else begin
            ev_plain.kind        = EV_DATA;
        end
    end

    // Next state and event decode
    always_comb begin
        n_state      = r_state;
        n_sub_active = r_sub_active;
        n_sub_option = r_sub_option;
        n_neg_verb   = r_neg_verb;
        ev_has       = 1'b0;
        ev           = '0;
        ev.kind      = EV_DATA;
        unique case (r_state)
            ST_DATA: begin
                if (i_rx_byte == CODE_IAC) begin
                    n_state = ST_CMD;
                end else begin
                    ev_has = 1'b1;
                    ev     = ev_plain;
                end
            end
            ST_CMD: begin
                n_state = ST_DATA;
                priority if (i_rx_byte == CODE_SE) begin
                    ev_has = 1'b1;
                    if (r_sub_active) begin
                        ev.kind        = EV_SUBEND;
                        ev.option_code = r_sub_option;
                        n_sub_active   = 1'b0;
                        n_sub_option   = '0;
                    end else begin
                        ev.kind       = EV_ERR;
                        ev.error_code = ERR_SE_NO_SB;
                    end
                end else if (i_rx_byte == CODE_SB) begin
                    if (r_sub_active) begin
                        ev_has        = 1'b1;
                        ev.kind       = EV_ERR;
                        ev.error_code = ERR_SB_NESTED;
                    end else begin
                        n_state = ST_SUBOPT;
                    end
                end else if (i_rx_byte >= CODE_WILL && i_rx_byte <= CODE_DONT) begin
                    n_neg_verb = i_rx_byte;
                    n_state    = ST_OPT;
                end else if (i_rx_byte == CODE_IAC) begin
                    // escaped IAC is a data byte
                    ev_has = 1'b1;
                    ev     = ev_plain;
                end else begin
                    ev_has        = 1'b1;
                    ev.kind       = EV_CMD;
                    ev.byte_value = i_rx_byte;
                end
            end
            ST_OPT: begin
                n_state        = ST_DATA;
                ev_has         = 1'b1;
                ev.kind        = EV_NEG;
                ev.byte_value  = r_neg_verb;
                ev.option_code = i_rx_byte;
            end
            ST_SUBOPT: begin
                n_state      = ST_DATA;
                n_sub_active = 1'b1;
                n_sub_option = i_rx_byte;
            end
            default: begin
                n_state = ST_DATA;
            end
        endcase
    end

    // State registers, updated on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_DATA;
            r_sub_active <= 1'b0;
            r_sub_option <= '0;
            r_neg_verb   <= '0;
        end else if (i_accept) begin
            r_state      <= n_state;
            r_sub_active <= n_sub_active;
            r_sub_option <= n_sub_option;
            r_neg_verb   <= n_neg_verb;
        end
    end

    assign o_ev_valid = i_accept && ev_has;
    assign o_ev       = ev;

`ifndef NO_ASSERTIONS
    // Subnegotiation end closes the subnegotiation
    a_subend_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid && o_ev.kind == EV_SUBEND |=> !r_sub_active && r_sub_option == 8'd0)
        else $error("subnegotiation still open after its end event");

    // Nested SB error keeps the open subnegotiation
    a_nested_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev_valid && o_ev.kind == EV_ERR && o_ev.error_code == ERR_SB_NESTED
        |=> r_sub_active && r_state == ST_DATA)
        else $error("nested SB error lost the open subnegotiation");

    // A subnegotiation option byte always opens a subnegotiation
    a_subopt_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_state == ST_SUBOPT |=> r_sub_active && r_sub_option == $past(i_rx_byte))
        else $error("subnegotiation option not captured");
`endif

endmodule

[rtl/core/telrx_outbuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telrx_outbuf: result register with skid stage
// Holds the event beat for the output channel; a skid register takes one
// more beat while the output is stalled so the input side keeps flowing.
// ----------------------------------------------------------------------------
module telrx_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  telrx_pkg::t_event i_ev,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output telrx_pkg::t_event o_ev
);
    import telrx_pkg::*;

    logic   r_out_valid;
    logic   r_skid_valid;
    t_event r_out;
    t_event r_skid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_ev;
        end else if (i_push) begin
            r_skid <= i_ev;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_ev    = r_out;

`ifndef NO_ASSERTIONS
    // Skid only fills behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat without output beat");

    // A beat pushed against a stalled output lands in the skid
    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && r_out_valid && i_stall |=> r_skid_valid && r_skid == $past(i_ev))
        else $error("beat lost while output stalled");

    // Skid drains into the output when the receiver takes a beat
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_stall |=> r_out_valid && !r_skid_valid && r_out == $past(r_skid))
        else $error("skid beat not moved to output");
`endif

endmodule

[rtl/core/telnet_receive_command_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_receive_command_parser_top: telnet IAC receive parser
// Usage:
//   Input channel: one received telnet byte per beat on i_rx_byte, with
//   i_valid / o_stall. A beat is taken when i_valid is high and o_stall low.
//   Output channel: at most one event per input beat on o_event_kind,
//   o_byte_value, o_option_code, o_error_code, with o_valid / i_stall.
//   Bytes that only advance the parse (IAC, a verb, SB, the option after SB) give no event.
//   Throughput: one byte per cycle while o_stall is low; the state machine
//   decides each byte in the cycle it is taken and writes the event into the
//   result register (the skid register while the output is stalled).
//   Receiver stall: the result register holds its beat and a skid register
//   takes one more event; o_stall rises only while the skid is occupied,
//   so no event is lost or repeated.
//   Reset (synchronous, active low): parser returns to the data state with
//   no subnegotiation open and no pending verb; both output registers
//   are emptied. No clearing pass is needed.
// ----------------------------------------------------------------------------
module telnet_receive_command_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_byte_value,
    output logic [7:0] o_option_code,
    output logic       o_error_code
);
    import telrx_pkg::*;

    logic   accept;
    logic   ev_valid;
    t_event ev;
    t_event out_ev;
    logic   buf_full;

    assign accept  = i_valid && !buf_full;
    assign o_stall = buf_full;

    telrx_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_ev_valid (ev_valid),
        .o_ev       (ev)
    );

    telrx_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ev_valid),
        .i_ev    (ev),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ev    (out_ev)
    );

    assign o_event_kind  = out_ev.kind;
    assign o_byte_value  = out_ev.byte_value;
    assign o_option_code = out_ev.option_code;
    assign o_error_code  = out_ev.error_code;

endmodule

[verif/tb_telnet_receive_command_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_telnet_receive_command_parser_top: testbench for the telnet IAC parser
// Feeds received bytes: first a directed stream over every command form and
// every error, then random telnet traffic made mostly of well-formed command,
// negotiation and subnegotiation sequences. A scoreboard class tracks the
// parser state, predicts the event for each byte and checks every event
// beat in order. The sender idles in bursts and the receiver stalls on its
// own pattern.
// ----------------------------------------------------------------------------
module tb_telnet_receive_command_parser_top;
    import telrx_pkg::*;

    // Verb and command codes the package does not name
    localparam logic [7:0] VERB_WONT = 8'd252;
    localparam logic [7:0] VERB_DO   = 8'd253;
    localparam logic [7:0] CODE_NOP  = 8'd241;

    localparam int RANDOM_BYTES = 2000;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;

    // Tracks parser state and holds the events still to arrive
    class telnet_event_scoreboard;
        t_parse_state parse_st;
        logic         sub_open;
        logic [7:0]   sub_opt;
        logic [7:0]   pending_verb;
        t_event       pending_events[$];
        int           mismatches;

        function new();
            parse_st     = ST_DATA;
            sub_open     = 1'b0;
            sub_opt      = 8'd0;
            pending_verb = 8'd0;
            mismatches   = 0;
        endfunction

        // A byte that reaches the data layer, plain or inside a subnegotiation
        function t_event data_event(logic [7:0] rx);
            t_event ev;
            ev = '0;
            ev.byte_value = rx;
            if (sub_open) begin
                ev.kind        = EV_SUBDAT;
                ev.option_code = sub_opt;
            end else begin
                ev.kind = EV_DATA;
            end
            return ev;
        endfunction

        // Advance the parse by one accepted byte and queue its event, if any
        function void note_rx_byte(logic [7:0] rx);
            t_event ev;
            logic   has_ev;
            ev     = '0;
            has_ev = 1'b0;
            case (parse_st)
                ST_DATA: begin
                    if (rx == CODE_IAC) begin
                        parse_st = ST_CMD;
                    end else begin
                        ev     = data_event(rx);
                        has_ev = 1'b1;
                    end
                end
                ST_CMD: begin
                    if (rx == CODE_SE) begin
                        parse_st = ST_DATA;
                        has_ev   = 1'b1;
                        if (!sub_open) begin
                            ev.kind       = EV_ERR;
                            ev.error_code = ERR_SE_NO_SB;
                        end else begin
                            ev.kind        = EV_SUBEND;
                            ev.option_code = sub_opt;
                            sub_open       = 1'b0;
                            sub_opt        = 8'd0;
                        end
                    end else if (rx == CODE_SB) begin
                        if (sub_open) begin
                            // nested SB: error, open subnegotiation kept
                            parse_st      = ST_DATA;
                            has_ev        = 1'b1;
                            ev.kind       = EV_ERR;
                            ev.error_code = ERR_SB_NESTED;
                        end else begin
                            parse_st = ST_SUBOPT;
                        end
                    end else if (rx >= CODE_WILL && rx <= CODE_DONT) begin
                        pending_verb = rx;
                        parse_st     = ST_OPT;
                    end else begin
                        parse_st = ST_DATA;
                        has_ev   = 1'b1;
                        if (rx == CODE_IAC) begin
                            ev = data_event(rx);
                        end else begin
                            ev.kind       = EV_CMD;
                            ev.byte_value = rx;
                        end
                    end
                end
                ST_OPT: begin
                    // option byte taken whatever its value
                    parse_st       = ST_DATA;
                    has_ev         = 1'b1;
                    ev.kind        = EV_NEG;
                    ev.byte_value  = pending_verb;
                    ev.option_code = rx;
                end
                default: begin
                    sub_opt  = rx;
                    sub_open = 1'b1;
                    parse_st = ST_DATA;
                end
            endcase
            if (has_ev) begin
                pending_events.push_back(ev);
            end
        endfunction

        // Compare one event beat with the oldest expectation
        function void check_event(t_event got);
            t_event want;
            if (pending_events.size() == 0) begin
                $error("unexpected event beat: kind %0d byte %0d option %0d error %0d",
                       got.kind, got.byte_value, got.option_code, got.error_code);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            if (got.kind !== want.kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.byte_value !== want.byte_value) begin
                $error("byte_value: expected %0d, got %0d", want.byte_value, got.byte_value);
                mismatches++;
            end
            if (got.option_code !== want.option_code) begin
                $error("option_code: expected %0d, got %0d",
                       want.option_code, got.option_code);
                mismatches++;
            end
            if (got.error_code !== want.error_code) begin
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
                mismatches++;
            end
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_event_kind;
    logic [7:0] o_byte_value;
    logic [7:0] o_option_code;
    logic       o_error_code;

    telnet_event_scoreboard event_board = new();

    int burst_left   = 0;
    int bytes_sent   = 0;
    int idle_cycles  = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int stall_phase  = 0;

    always #5 i_clk = ~i_clk;

    telnet_receive_command_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_event_kind  (o_event_kind),
        .o_byte_value  (o_byte_value),
        .o_option_code (o_option_code),
        .o_error_code  (o_error_code)
    );

    // Send one byte beat; the sender idles between bursts of random length
    task automatic push_rx_byte(input logic [7:0] rx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
        event_board.note_rx_byte(rx);
    endtask

    // Random telnet traffic: mostly well-formed sequences, some noise
    task automatic push_random_sequence();
        int         pick;
        int         n_data;
        logic [7:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            push_rx_byte(8'($urandom_range(0, 254)));
        end else if (pick < 42) begin
            push_rx_byte(CODE_IAC);
            push_rx_byte(CODE_IAC);
        end else if (pick < 57) begin
            push_rx_byte(CODE_IAC);
            push_rx_byte(8'($urandom_range(CODE_WILL, CODE_DONT)));
            push_rx_byte(8'($urandom_range(0, 255)));
        end else if (pick < 67) begin
            // plain command, assigned or not
            code = 8'($urandom_range(0, 249));
            if (code == CODE_SE) begin
                code = CODE_NOP;
            end
            push_rx_byte(CODE_IAC);
            push_rx_byte(code);
        end else if (pick < 83) begin
            // full subnegotiation with random payload
            push_rx_byte(CODE_IAC);
            push_rx_byte(CODE_SB);
            push_rx_byte(8'($urandom_range(0, 255)));
            n_data = $urandom_range(0, 6);
            for (int k = 0; k < n_data; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    push_rx_byte(CODE_IAC);
                    push_rx_byte(CODE_IAC);
                end else begin
                    push_rx_byte(8'($urandom_range(0, 254)));
                end
            end
            push_rx_byte(CODE_IAC);
            push_rx_byte(CODE_SE);
        end else if (pick < 88) begin
            push_rx_byte(CODE_IAC);
            push_rx_byte(CODE_SE);
        end else if (pick < 92) begin
            // SB left open, or nested inside one already open
            push_rx_byte(CODE_IAC);
            push_rx_byte(CODE_SB);
            if (!event_board.sub_open) begin
                push_rx_byte(8'($urandom_range(0, 255)));
            end
        end else begin
            push_rx_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Receiver side: stall pattern, event checking and the watchdog
    always @(posedge i_clk) begin : event_side
        t_event got;
        logic   took_any;
        got      = '0;
        took_any = 1'b0;

        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(32, 200);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % 16;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 9) < 3);
            2:       i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= (stall_phase < 11);
        endcase

        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.kind        = t_event_kind'(o_event_kind);
                got.byte_value  = o_byte_value;
                got.option_code = o_option_code;
                got.error_code  = o_error_code;
                event_board.check_event(got);
                took_any = 1'b1;
            end
            if (i_valid && !o_stall) begin
                took_any = 1'b1;
            end
            idle_cycles = took_any ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Reset, directed bytes, random traffic, drain
    initial begin : stimulus
        static logic [7:0] directed_bytes[] = '{
            8'h00, 8'hFE,                        // data extremes
            CODE_IAC, CODE_IAC,                  // escaped 255
            CODE_IAC, CODE_NOP,                  // plain command
            CODE_IAC, CODE_WILL, 8'h01,
            CODE_IAC, VERB_WONT, CODE_IAC,       // IAC as option
            CODE_IAC, VERB_DO, CODE_SE,          // SE as option
            CODE_IAC, CODE_SE,                   // SE without SB
            CODE_IAC, CODE_SB, 8'h18,
            8'h80,                               // subneg data
            CODE_IAC, CODE_SB,                   // nested SB
            CODE_IAC, CODE_DONT, 8'h00,
            CODE_IAC, CODE_SE,                   // subneg end
            CODE_IAC, CODE_SB, CODE_IAC,         // IAC as subneg option
            CODE_IAC, CODE_SE
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[k]) begin
            push_rx_byte(directed_bytes[k]);
        end
        while (bytes_sent < RANDOM_BYTES + directed_bytes.size()) begin
            push_random_sequence();
        end
        i_valid <= 1'b0;

        // wait out the events still in flight
        while (event_board.pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (event_board.mismatches == 0 && event_board.pending_events.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
